// File: design/ssswp_pkg.sv
// ----------------------------------------------------------------------------
// ssswp_pkg
// Shared types and constants of the single shunt sample window planner.
// ----------------------------------------------------------------------------
package ssswp_pkg;

   localparam int DUTY_FRAC_BITS = 16;
   localparam int DUTY_W         = DUTY_FRAC_BITS + 1;
   localparam int GUARD_W        = DUTY_FRAC_BITS + 2;
   localparam int POS_W          = DUTY_FRAC_BITS + 4;
   localparam int SUM_W          = POS_W + 1;
   localparam int PERIOD_W       = 16;
   localparam int TICK_W         = 16;
   localparam int HTICK_W        = 15;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 18;
   localparam int REQ_W          = 56;
   localparam int RSP_W          = 96;
   localparam int NUM_W          = GUARD_W + DUTY_FRAC_BITS;
   localparam int Q_DEPTH        = 4;
   localparam int Q_PTR_W        = $clog2(Q_DEPTH);

   localparam logic [DUTY_W-1:0]  ONE       = DUTY_W'(1) << DUTY_FRAC_BITS;
   localparam logic [GUARD_W-1:0] GUARD_MAX = '1;

   localparam logic [1:0] PHASE_NONE  = 2'd0;
   localparam logic [1:0] PHASE_LEAD  = 2'd1;
   localparam logic [1:0] PHASE_TRAIL = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_PERIOD    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_DEADTIME  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_APERTURE  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_DUTY  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_MARGIN    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_ZLIMIT    = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_COUNT = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_EDGE_MID  = 3'd7;

   localparam logic [15:0] RST_PERIOD    = 16'd10000;
   localparam logic [15:0] RST_DEADTIME  = 16'd100;
   localparam logic [15:0] RST_APERTURE  = 16'd50;
   localparam logic [16:0] RST_MIN_DUTY  = 17'd3277;
   localparam logic [16:0] RST_MARGIN    = 17'd1311;
   localparam logic [17:0] RST_ZLIMIT    = 18'd98304;
   localparam logic [1:0]  RST_MIN_COUNT = 2'd2;
   localparam logic [16:0] RST_EDGE_MID  = 17'd32768;

   typedef struct packed {
      logic                      ready;
      logic [17:0]               thr;
      logic [1:0]                min_cnt;
      logic [DUTY_W-1:0]         edge_mid;
      logic [17:0]               zlimit;
      logic [GUARD_W-1:0]        guard;
      logic [DUTY_W-1:0]         mh;
      logic signed [POS_W-1:0]   dlow;
      logic signed [POS_W-1:0]   dhigh;
      logic signed [POS_W-1:0]   lead_a;
      logic [PERIOD_W-1:0]       period;
   } cfg_type;

   typedef struct packed {
      logic                      valid;
      logic [1:0]                count;
      logic                      comp;
      logic                      zhigh;
      logic                      pref;
      logic [DUTY_W-1:0]         x;
      logic [DUTY_W-1:0]         y;
      logic [1:0]                pha;
      logic [1:0]                phb;
      logic signed [POS_W-1:0]   pa;
      logic signed [POS_W-1:0]   pb;
      logic                      chain;
   } plan_type;

   typedef struct packed {
      logic                      last;
      logic                      valid;
      logic [1:0]                count;
      logic                      comp;
      logic                      zhigh;
      logic                      pref;
      logic [DUTY_W-1:0]         duty;
      logic [1:0]                phase;
   } meta_type;

   function automatic logic signed [SUM_W-1:0] clamp_pos(
      input logic signed [SUM_W-1:0] v,
      input logic signed [SUM_W-1:0] lo,
      input logic signed [SUM_W-1:0] hi);
      logic signed [SUM_W-1:0] r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// File: design/ssswp_cfg.sv
// ----------------------------------------------------------------------------
// ssswp_cfg
// Control registers, iterative guard divider and derived window bounds.
// ----------------------------------------------------------------------------
module ssswp_cfg (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [ssswp_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [ssswp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output ssswp_pkg::cfg_type                    cfg
);

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_SUM   = 3'd2;
   localparam logic [2:0] ST_DER1  = 3'd3;
   localparam logic [2:0] ST_DER2  = 3'd4;
   localparam logic [2:0] ST_READY = 3'd5;

   localparam int CNT_W = $clog2(ssswp_pkg::NUM_W);
   localparam int DIV_W = ssswp_pkg::PERIOD_W + 1;

   logic [2:0]  state_ff, state_in;
   logic [15:0] period_ff, period_in;
   logic [15:0] dead_ff, dead_in;
   logic [15:0] aper_ff, aper_in;
   logic [16:0] min_duty_ff, min_duty_in;
   logic [16:0] margin_ff, margin_in;
   logic [17:0] zlimit_ff, zlimit_in;
   logic [1:0]  min_cnt_ff, min_cnt_in;
   logic [16:0] edge_mid_ff, edge_mid_in;

   logic [ssswp_pkg::NUM_W-1:0]    quo_ff, quo_in;
   logic [DIV_W-1:0]               rem_ff, rem_in;
   logic [DIV_W-1:0]               divisor_ff, divisor_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [15:0]                    per_eff_ff, per_eff_in;
   logic [ssswp_pkg::GUARD_W-1:0]  guard_ff, guard_in;
   logic [ssswp_pkg::DUTY_W-1:0]   mh_ff, mh_in;
   logic [17:0]                    thr_ff, thr_in;
   logic signed [ssswp_pkg::POS_W-1:0] dlow_ff, dlow_in;
   logic signed [ssswp_pkg::POS_W-1:0] dhigh_ff, dhigh_in;
   logic signed [ssswp_pkg::POS_W-1:0] lead_ff, lead_in;

   logic [DIV_W:0]                 rem_sh;
   logic                           take;
   logic [17:0]                    num_hi;
   logic [ssswp_pkg::GUARD_W:0]    gsum;
   logic signed [ssswp_pkg::POS_W-1:0] dhigh_c;
   logic signed [ssswp_pkg::SUM_W-1:0] lead_sum;

   always_comb begin
      state_in    = state_ff;
      period_in   = period_ff;
      dead_in     = dead_ff;
      aper_in     = aper_ff;
      min_duty_in = min_duty_ff;
      margin_in   = margin_ff;
      zlimit_in   = zlimit_ff;
      min_cnt_in  = min_cnt_ff;
      edge_mid_in = edge_mid_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      cnt_in      = cnt_ff;
      per_eff_in  = per_eff_ff;
      guard_in    = guard_ff;
      mh_in       = mh_ff;
      thr_in      = thr_ff;
      dlow_in     = dlow_ff;
      dhigh_in    = dhigh_ff;
      lead_in     = lead_ff;

      rem_sh   = {rem_ff, quo_ff[ssswp_pkg::NUM_W-1]};
      take     = (rem_sh >= {1'b0, divisor_ff});
      num_hi   = {1'b0, dead_ff, 1'b0} + {2'b00, aper_ff};
      gsum     = {2'b00, margin_ff} + {1'b0, quo_ff[ssswp_pkg::GUARD_W-1:0]};
      dhigh_c  = $signed({{(ssswp_pkg::POS_W-ssswp_pkg::DUTY_W){1'b0}}, ssswp_pkg::ONE})
                 - dlow_ff;
      lead_sum = {dlow_ff[ssswp_pkg::POS_W-1], dlow_ff}
                 + $signed({3'b000, guard_ff});

      case (state_ff)
         ST_LOAD: begin
            per_eff_in = (period_ff == 16'd0) ? 16'd1 : period_ff;
            divisor_in = {((period_ff == 16'd0) ? 16'd1 : period_ff), 1'b0};
            quo_in     = {num_hi, {ssswp_pkg::DUTY_FRAC_BITS{1'b0}}};
            rem_in     = '0;
            cnt_in     = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            rem_in = take ? DIV_W'(rem_sh - {1'b0, divisor_ff}) : rem_sh[DIV_W-1:0];
            quo_in = {quo_ff[ssswp_pkg::NUM_W-2:0], take};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ssswp_pkg::NUM_W - 1)) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if ((|quo_ff[ssswp_pkg::NUM_W-1:ssswp_pkg::GUARD_W])
                || gsum[ssswp_pkg::GUARD_W]) begin
               guard_in = ssswp_pkg::GUARD_MAX;
            end else begin
               guard_in = gsum[ssswp_pkg::GUARD_W-1:0];
            end
            state_in = ST_DER1;
         end
         ST_DER1: begin
            mh_in    = guard_ff[ssswp_pkg::GUARD_W-1:1];
            dlow_in  = $signed({3'b000, min_duty_ff})
                       + $signed({3'b000, guard_ff[ssswp_pkg::GUARD_W-1:1]});
            thr_in   = {1'b0, min_duty_ff} + {1'b0, margin_ff};
            state_in = ST_DER2;
         end
         ST_DER2: begin
            dhigh_in = dhigh_c;
            lead_in  = $signed(ssswp_pkg::clamp_pos(lead_sum,
                          {dlow_ff[ssswp_pkg::POS_W-1], dlow_ff},
                          {dhigh_c[ssswp_pkg::POS_W-1], dhigh_c})
                          [ssswp_pkg::POS_W-1:0]);
            state_in = ST_READY;
         end
         ST_READY: begin
            state_in = ST_READY;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (csr_we) begin
         state_in = ST_LOAD;
         case (csr_addr)
            ssswp_pkg::REG_PERIOD:    period_in   = csr_wdata[15:0];
            ssswp_pkg::REG_DEADTIME:  dead_in     = csr_wdata[15:0];
            ssswp_pkg::REG_APERTURE:  aper_in     = csr_wdata[15:0];
            ssswp_pkg::REG_MIN_DUTY:  min_duty_in = csr_wdata[16:0];
            ssswp_pkg::REG_MARGIN:    margin_in   = csr_wdata[16:0];
            ssswp_pkg::REG_ZLIMIT:    zlimit_in   = csr_wdata[17:0];
            ssswp_pkg::REG_MIN_COUNT: min_cnt_in  = csr_wdata[1:0];
            ssswp_pkg::REG_EDGE_MID:  edge_mid_in = csr_wdata[16:0];
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         period_ff   <= ssswp_pkg::RST_PERIOD;
         dead_ff     <= ssswp_pkg::RST_DEADTIME;
         aper_ff     <= ssswp_pkg::RST_APERTURE;
         min_duty_ff <= ssswp_pkg::RST_MIN_DUTY;
         margin_ff   <= ssswp_pkg::RST_MARGIN;
         zlimit_ff   <= ssswp_pkg::RST_ZLIMIT;
         min_cnt_ff  <= ssswp_pkg::RST_MIN_COUNT;
         edge_mid_ff <= ssswp_pkg::RST_EDGE_MID;
      end else begin
         state_ff    <= state_in;
         period_ff   <= period_in;
         dead_ff     <= dead_in;
         aper_ff     <= aper_in;
         min_duty_ff <= min_duty_in;
         margin_ff   <= margin_in;
         zlimit_ff   <= zlimit_in;
         min_cnt_ff  <= min_cnt_in;
         edge_mid_ff <= edge_mid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      cnt_ff     <= cnt_in;
      per_eff_ff <= per_eff_in;
      guard_ff   <= guard_in;
      mh_ff      <= mh_in;
      thr_ff     <= thr_in;
      dlow_ff    <= dlow_in;
      dhigh_ff   <= dhigh_in;
      lead_ff    <= lead_in;
   end

   always_comb begin
      cfg.ready    = (state_ff == ST_READY);
      cfg.thr      = thr_ff;
      cfg.min_cnt  = min_cnt_ff;
      cfg.edge_mid = edge_mid_ff;
      cfg.zlimit   = zlimit_ff;
      cfg.guard    = guard_ff;
      cfg.mh       = mh_ff;
      cfg.dlow     = dlow_ff;
      cfg.dhigh    = dhigh_ff;
      cfg.lead_a   = lead_ff;
      cfg.period   = per_eff_ff;
   end

endmodule

// File: design/ssswp_front.sv
// ----------------------------------------------------------------------------
// ssswp_front
// Accepts commands, picks the active duties and plans both windows.
// ----------------------------------------------------------------------------
module ssswp_front (
   input  logic                            clock,
   input  logic                            reset,
   input  ssswp_pkg::cfg_type              cfg,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ssswp_pkg::REQ_W-1:0]     req_tdata,
   output logic                            push_valid,
   input  logic                            push_ready,
   output ssswp_pkg::plan_type             push_data
);

   localparam int DW = ssswp_pkg::DUTY_W;
   localparam int SW = ssswp_pkg::SUM_W;
   localparam int PW = ssswp_pkg::POS_W;

   logic                f1_v_ff, f1_v_in;
   logic [DW-1:0]       x_ff, x_in;
   logic [DW-1:0]       y_ff, y_in;
   logic                zhigh_ff, zhigh_in;
   logic                f2_v_ff, f2_v_in;
   ssswp_pkg::plan_type plan_ff, plan_in;

   logic [2:0]          sector;
   logic [DW-1:0]       da, db, dc;
   logic [DW+1:0]       dsum;
   logic                accept, f2_adv;
   logic [DW-1:0]       mn;
   logic                gx, gy, comp, pref;
   logic [1:0]          cnt;
   logic signed [SW-1:0] dlow_s, dhigh_s, xm, ym;

   assign sector = req_tdata[2:0];
   assign da     = req_tdata[19:3];
   assign db     = req_tdata[36:20];
   assign dc     = req_tdata[53:37];
   assign dsum   = {2'b00, da} + {2'b00, db} + {2'b00, dc};

   assign f2_adv     = !f2_v_ff || push_ready;
   assign req_tready = cfg.ready && (!f1_v_ff || f2_adv);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      zhigh_in = zhigh_ff;
      f1_v_in  = f1_v_ff;
      if (f2_adv) begin
         f1_v_in = 1'b0;
      end
      if (accept) begin
         f1_v_in  = 1'b1;
         zhigh_in = (dsum < {1'b0, cfg.zlimit});
         case (sector)
            3'd1: begin x_in = da; y_in = db; end
            3'd2: begin x_in = da; y_in = dc; end
            3'd3: begin x_in = db; y_in = dc; end
            3'd4: begin x_in = db; y_in = da; end
            3'd5: begin x_in = dc; y_in = da; end
            3'd6: begin x_in = dc; y_in = db; end
            default: begin x_in = '0; y_in = '0; end
         endcase
      end
   end

   always_comb begin
      mn      = (x_ff < y_ff) ? x_ff : y_ff;
      gx      = ({1'b0, x_ff} > cfg.thr);
      gy      = ({1'b0, y_ff} > cfg.thr);
      cnt     = {1'b0, gx} + {1'b0, gy};
      comp    = (cnt < cfg.min_cnt);
      pref    = (x_ff >= y_ff);
      dlow_s  = {cfg.dlow[PW-1], cfg.dlow};
      dhigh_s = {cfg.dhigh[PW-1], cfg.dhigh};
      xm      = $signed({{(SW-DW){1'b0}}, x_ff}) - $signed({{(SW-DW){1'b0}}, cfg.mh});
      ym      = $signed({{(SW-DW){1'b0}}, y_ff}) - $signed({{(SW-DW){1'b0}}, cfg.mh});

      plan_in       = plan_ff;
      plan_in.valid = ({1'b0, mn} > cfg.thr);
      plan_in.count = cnt;
      plan_in.comp  = comp;
      plan_in.pref  = pref;
      plan_in.zhigh = comp ? pref : zhigh_ff;
      plan_in.x     = x_ff;
      plan_in.y     = y_ff;
      plan_in.chain = 1'b0;
      plan_in.pha   = ssswp_pkg::PHASE_NONE;
      plan_in.phb   = ssswp_pkg::PHASE_NONE;
      plan_in.pa    = '0;
      plan_in.pb    = '0;

      if ({1'b0, x_ff} > cfg.guard) begin
         if (x_ff >= cfg.edge_mid) begin
            plan_in.pha = ssswp_pkg::PHASE_TRAIL;
            plan_in.pa  = xm[PW-1:0];
         end else begin
            plan_in.pha = ssswp_pkg::PHASE_LEAD;
            plan_in.pa  = cfg.dlow;
         end
      end
      if ({1'b0, y_ff} > cfg.guard) begin
         if (y_ff >= cfg.edge_mid) begin
            plan_in.phb = ssswp_pkg::PHASE_TRAIL;
            plan_in.pb  = ym[PW-1:0];
         end else begin
            plan_in.phb = ssswp_pkg::PHASE_LEAD;
            plan_in.pb  = cfg.dlow;
         end
      end

      if (comp) begin
         if (pref) begin
            plan_in.pha   = ssswp_pkg::PHASE_TRAIL;
            plan_in.phb   = ssswp_pkg::PHASE_TRAIL;
            plan_in.pa    = $signed(ssswp_pkg::clamp_pos(xm, dlow_s, dhigh_s)[PW-1:0]);
            plan_in.chain = 1'b1;
         end else begin
            plan_in.pha = ssswp_pkg::PHASE_LEAD;
            plan_in.phb = ssswp_pkg::PHASE_LEAD;
            plan_in.pa  = cfg.lead_a;
            plan_in.pb  = cfg.dlow;
         end
      end

      f2_v_in = f2_v_ff;
      if (f2_adv) begin
         f2_v_in = f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else begin
         f1_v_ff <= f1_v_in;
         f2_v_ff <= f2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      zhigh_ff <= zhigh_in;
      if (f2_adv) begin
         plan_ff <= plan_in;
      end
   end

   assign push_valid = f2_v_ff;
   assign push_data  = plan_ff;

endmodule

// File: design/ssswp_queue.sv
// ----------------------------------------------------------------------------
// ssswp_queue
// Short plan queue between the front and back parts.
// ----------------------------------------------------------------------------
module ssswp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  ssswp_pkg::plan_type  push_data,
   output logic                 head_valid,
   input  logic                 pop,
   output ssswp_pkg::plan_type  head_data
);

   localparam int PTR_W = ssswp_pkg::Q_PTR_W;

   ssswp_pkg::plan_type     mem_ff [ssswp_pkg::Q_DEPTH];
   logic [PTR_W-1:0]        wr_ff, wr_in;
   logic [PTR_W-1:0]        rd_ff, rd_in;
   logic [PTR_W:0]          cnt_ff, cnt_in;
   logic                    do_push, do_pop;

   assign push_ready = (cnt_ff != (PTR_W+1)'(ssswp_pkg::Q_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: design/ssswp_back.sv
// ----------------------------------------------------------------------------
// ssswp_back
// Emits windows A and B: final position, half-cycle position and ticks.
// ----------------------------------------------------------------------------
module ssswp_back (
   input  logic                            clock,
   input  logic                            reset,
   input  ssswp_pkg::cfg_type              cfg,
   input  logic                            head_valid,
   input  ssswp_pkg::plan_type             head_data,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ssswp_pkg::RSP_W-1:0]     rsp_tdata,
   output logic                            rsp_tlast
);

   localparam int DW = ssswp_pkg::DUTY_W;
   localparam int SW = ssswp_pkg::SUM_W;
   localparam int PW = ssswp_pkg::POS_W;
   localparam int FB = ssswp_pkg::DUTY_FRAC_BITS;

   logic                 beat_ff, beat_in;
   logic                 b1_v_ff, b1_v_in;
   logic                 b2_v_ff, b2_v_in;
   logic                 out_v_ff, out_v_in;
   ssswp_pkg::meta_type  b1_meta_ff, b1_meta_in;
   ssswp_pkg::meta_type  b2_meta_ff;
   ssswp_pkg::meta_type  out_meta_ff;
   logic signed [PW-1:0] b1_pos_ff, b1_pos_in;
   logic [DW-1:0]        b2_p_ff, b2_p_in;
   logic [DW-1:0]        b2_hp_ff, b2_hp_in;
   logic [DW-1:0]        out_p_ff;
   logic [DW-1:0]        out_hp_ff;
   logic [ssswp_pkg::TICK_W-1:0]  out_tick_ff, out_tick_in;
   logic [ssswp_pkg::HTICK_W-1:0] out_htick_ff, out_htick_in;

   logic                 out_adv, b2_adv, b1_adv, issue;
   logic signed [SW-1:0] chain_sum;
   logic signed [PW:0]   p2m;
   logic [DW:0]          p2;
   logic [DW+ssswp_pkg::PERIOD_W-1:0] tick_prod, htick_prod;

   assign out_adv = !out_v_ff || rsp_tready;
   assign b2_adv  = !b2_v_ff || out_adv;
   assign b1_adv  = !b1_v_ff || b2_adv;
   assign issue   = head_valid && b1_adv;
   assign pop     = issue && beat_ff;

   // window select and chained B position
   always_comb begin
      chain_sum = {head_data.pa[PW-1], head_data.pa}
                  + $signed({{(SW-ssswp_pkg::GUARD_W){1'b0}}, cfg.guard});
      beat_in = issue ? !beat_ff : beat_ff;
      b1_v_in = b1_adv ? issue : b1_v_ff;

      b1_meta_in.last  = beat_ff;
      b1_meta_in.valid = head_data.valid;
      b1_meta_in.count = head_data.count;
      b1_meta_in.comp  = head_data.comp;
      b1_meta_in.zhigh = head_data.zhigh;
      b1_meta_in.pref  = head_data.pref;
      if (!beat_ff) begin
         b1_meta_in.duty  = head_data.x;
         b1_meta_in.phase = head_data.pha;
         b1_pos_in        = head_data.pa;
      end else begin
         b1_meta_in.duty  = head_data.y;
         b1_meta_in.phase = head_data.phb;
         if (head_data.chain) begin
            b1_pos_in = $signed(ssswp_pkg::clamp_pos(chain_sum,
                           {cfg.dlow[PW-1], cfg.dlow},
                           {cfg.dhigh[PW-1], cfg.dhigh})[PW-1:0]);
         end else begin
            b1_pos_in = head_data.pb;
         end
      end
   end

   // cycle and half-cycle position
   always_comb begin
      b2_v_in = b2_adv ? b1_v_ff : b2_v_ff;
      if (b1_pos_ff < 0) begin
         b2_p_in = '0;
      end else if (b1_pos_ff > $signed({{(PW-DW){1'b0}}, ssswp_pkg::ONE})) begin
         b2_p_in = ssswp_pkg::ONE;
      end else begin
         b2_p_in = b1_pos_ff[DW-1:0];
      end
      p2  = {b2_p_in, 1'b0};
      p2m = $signed({{(PW-DW){1'b0}}, p2}) - $signed({{(PW-DW+1){1'b0}}, ssswp_pkg::ONE});
      case (b1_meta_ff.phase)
         ssswp_pkg::PHASE_TRAIL: begin
            if (p2m < 0) begin
               b2_hp_in = '0;
            end else if (p2m > $signed({{(PW-DW+1){1'b0}}, ssswp_pkg::ONE})) begin
               b2_hp_in = ssswp_pkg::ONE;
            end else begin
               b2_hp_in = p2m[DW-1:0];
            end
         end
         ssswp_pkg::PHASE_LEAD: begin
            b2_hp_in = (p2 > {1'b0, ssswp_pkg::ONE}) ? ssswp_pkg::ONE : p2[DW-1:0];
         end
         default: begin
            b2_hp_in = '0;
         end
      endcase
   end

   // tick conversion
   always_comb begin
      out_v_in     = out_adv ? b2_v_ff : out_v_ff;
      tick_prod    = b2_p_ff * cfg.period;
      htick_prod   = b2_hp_ff * cfg.period;
      out_tick_in  = tick_prod[FB+ssswp_pkg::TICK_W-1:FB];
      out_htick_in = htick_prod[FB+ssswp_pkg::HTICK_W:FB+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= 1'b0;
         b1_v_ff  <= 1'b0;
         b2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         beat_ff  <= beat_in;
         b1_v_ff  <= b1_v_in;
         b2_v_ff  <= b2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b1_adv) begin
         b1_meta_ff <= b1_meta_in;
         b1_pos_ff  <= b1_pos_in;
      end
      if (b2_adv) begin
         b2_meta_ff <= b1_meta_ff;
         b2_p_ff    <= b2_p_in;
         b2_hp_ff   <= b2_hp_in;
      end
      if (out_adv) begin
         out_meta_ff  <= b2_meta_ff;
         out_p_ff     <= b2_p_ff;
         out_hp_ff    <= b2_hp_ff;
         out_tick_ff  <= out_tick_in;
         out_htick_ff <= out_htick_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast  = out_meta_ff.last;
   assign rsp_tdata  = {6'b000000, out_htick_ff, out_tick_ff, out_hp_ff, out_p_ff,
                        out_meta_ff.phase, out_meta_ff.duty, out_meta_ff.pref,
                        out_meta_ff.zhigh, out_meta_ff.comp, out_meta_ff.count,
                        out_meta_ff.valid};

endmodule

// File: design/single_shunt_sample_window_planner.sv
// ----------------------------------------------------------------------------
// single_shunt_sample_window_planner
// Turns a sector and three phase duties into two single-shunt ADC windows.
// ----------------------------------------------------------------------------
// window A path: front f1, f2, plan queue, back b1, b2 and output registers
// window B follows A through the shared emit pipe; the command is popped when B issues
// reset and every csr write: the guard divider runs 34 steps; commands wait until
//   the bounds are ready; synchronous active-high reset clears all control state
module single_shunt_sample_window_planner (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ssswp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [ssswp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // sector[2:0], duty_a[19:3], duty_b[36:20], duty_c[53:37], zero pad
   input  logic [ssswp_pkg::REQ_W-1:0]         req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // sample_valid[0], sample_count[2:1], needs_compensation[3], zero_vector_high[4],
   // prefer_high_window[5], window_duty[22:6], window_phase[24:23],
   // window_position[41:25], window_half_position[58:42], window_tick[74:59],
   // window_half_tick[89:75], zero pad
   output logic [ssswp_pkg::RSP_W-1:0]         rsp_tdata,
   output logic                                rsp_tlast
);

   ssswp_pkg::cfg_type   cfg;
   ssswp_pkg::plan_type  push_data;
   ssswp_pkg::plan_type  head_data;
   logic                 push_valid, push_ready;
   logic                 head_valid, pop;

   ssswp_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ssswp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ssswp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .head_valid (head_valid),
      .pop        (pop),
      .head_data  (head_data)
   );

   ssswp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: design/ssswp_checker.sv
// ----------------------------------------------------------------------------
// ssswp_checker
// Port-level checks of the window planner, bound to the top level.
// ----------------------------------------------------------------------------
module ssswp_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            rsp_tlast,
   input  logic [ssswp_pkg::RSP_W-1:0]     rsp_tdata
);

   logic want_b_ff, want_b_in;
   logic rsp_xfer;

   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      want_b_in = want_b_ff;
      if (rsp_xfer) begin
         want_b_in = !rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         want_b_ff <= 1'b0;
      end else begin
         want_b_ff <= want_b_in;
      end
   end

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // windows alternate a then b
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> (rsp_tlast == want_b_ff))
      else $error("window order broken");

   // guard is recomputed after reset before any command
   a_reset_hold: assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("command taken during guard update");

   // unplaced window has no half-cycle position
   a_unplaced: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[24:23] == ssswp_pkg::PHASE_NONE)
      |-> (rsp_tdata[58:42] == '0) && (rsp_tdata[89:75] == '0))
      else $error("half position on unplaced window");

   // reordered windows are always placed
   a_comp_placed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> (rsp_tdata[24:23] != ssswp_pkg::PHASE_NONE))
      else $error("reordered window left unplaced");

endmodule

bind single_shunt_sample_window_planner ssswp_checker u_checker (.*);
